@@ rtl/tsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants of the trigger timestamp sync checker.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int FIDUCIAL_MODULUS = 131040;

  // seconds per fiducial rollover
  localparam int ROLLOVER_SECS = FIDUCIAL_MODULUS / 360;
  localparam logic [31:0] ROLL_SECS_32 = 32'(ROLLOVER_SECS);

  // reciprocal of the rollover seconds, exact floor for any 32-bit dividend
  localparam int ROLL_LOG2 = $clog2(ROLLOVER_SECS);
  localparam int RECIP_SHIFT = 32 + ROLL_LOG2;
  localparam logic [32:0] RECIP =
    33'(((64'd1 << RECIP_SHIFT) + 64'(ROLLOVER_SECS - 1)) / 64'(ROLLOVER_SECS));

  localparam logic [31:0] FID_MOD_32 = 32'(FIDUCIAL_MODULUS);

  // request codes
  localparam logic [1:0] REQ_TRIGGER = 2'd0;
  localparam logic [1:0] REQ_RESET   = 2'd1;
  localparam logic [1:0] REQ_RESYNC  = 2'd2;
  localparam logic [1:0] REQ_NOP     = 2'd3;

  // configuration register indexes
  localparam logic [0:0] CFG_MAX_GAP      = 1'd0;
  localparam logic [0:0] CFG_UNSYNC_LIMIT = 1'd1;

  localparam logic [19:0] MAX_GAP_RESET      = 20'd21600;
  localparam logic [15:0] UNSYNC_LIMIT_RESET = 16'd240;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [16:0] fiducial;
    logic [31:0] clock_seconds;
    logic [29:0] clock_nanoseconds;
    logic        has_detector_data;
    logic [31:0] detector_time_ms;
  } in_item_t;

  typedef struct packed {
    logic        out_of_sync;
    logic        raise_alarm;
    logic [31:0] fiducial_delta;
    logic [15:0] unsync_frames;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ROLL,
    S_NFID,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic roll;
    logic nfid;
    logic cmp;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic in_trigger;
    logic out_free;
  } status_t;

endpackage

@@ rtl/tsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsc_ctrl
// Sequencer: steps a trigger through multiply, rollover, delta and check phases.
// ----------------------------------------------------------------------------
module tsc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  tsc_pkg::status_t status,
  output tsc_pkg::cmd_t    cmd
);

  tsc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      tsc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = status.in_trigger ? tsc_pkg::S_MUL : tsc_pkg::S_DONE;
        end
      end
      tsc_pkg::S_MUL: begin
        cmd.mul = 1'b1;
        state_next = tsc_pkg::S_ROLL;
      end
      tsc_pkg::S_ROLL: begin
        cmd.roll = 1'b1;
        state_next = tsc_pkg::S_NFID;
      end
      tsc_pkg::S_NFID: begin
        cmd.nfid = 1'b1;
        state_next = tsc_pkg::S_CMP;
      end
      tsc_pkg::S_CMP: begin
        cmd.cmp = 1'b1;
        state_next = tsc_pkg::S_DONE;
      end
      tsc_pkg::S_DONE: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = tsc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tsc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/tsc_datapath.sv @@
// ----------------------------------------------------------------------------
// tsc_datapath
// Time difference, rollover count, fiducial delta, sync test and state.
// ----------------------------------------------------------------------------
module tsc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  tsc_pkg::cmd_t      cmd,
  output tsc_pkg::status_t   status,
  input  tsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tsc_pkg::out_item_t out_data,
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  // configuration
  logic [19:0] max_gap;
  logic [15:0] unsync_limit;

  // block state
  logic        baseline_pending;
  logic        in_sync;
  logic        alarm_armed;
  logic [15:0] unsync_count;
  logic [16:0] base_fiducial;
  logic [31:0] base_seconds;
  logic [29:0] base_nanoseconds;
  logic [31:0] base_detector_time;

  // captured request
  tsc_pkg::in_item_t item;

  // working registers
  logic signed [32:0] dsec;
  logic signed [30:0] dnsec;
  logic [31:0]        quo;
  logic [31:0]        nroll;
  logic               pos;
  logic [31:0]        ddt;
  logic [31:0]        nfid;
  logic               fail;

  logic [64:0]        recip_prod;
  logic [31:0]        quo_back;
  logic               borrow;
  logic [31:0]        nfid_calc;
  logic [31:0]        fid_diff;
  logic [39:0]        a_term;
  logic [39:0]        b_term;
  logic [39:0]        abs_diff;
  logic               sync_next;
  logic [15:0]        count_inc;
  tsc_pkg::out_item_t res;

  assign status.in_trigger = (in_data.req_type == tsc_pkg::REQ_TRIGGER);
  assign status.out_free   = !out_valid || !out_stall;

  // whole rollovers: seconds over the rollover span by reciprocal multiply,
  // one less when the seconds divide evenly and the nanoseconds went backward
  assign recip_prod = {33'd0, dsec[31:0]} * {32'd0, tsc_pkg::RECIP};
  assign quo_back   = quo * tsc_pkg::ROLL_SECS_32;
  assign borrow     = (quo_back == dsec[31:0]) && dnsec[30];

  always_comb begin
    fid_diff = 32'(item.fiducial) - 32'(base_fiducial);
    if (nroll != '0) begin
      nfid_calc = 32'(tsc_pkg::FID_MOD_32 * nroll) + fid_diff;
    end else if (fid_diff[31]) begin
      nfid_calc = fid_diff + tsc_pkg::FID_MOD_32;
    end else begin
      nfid_calc = fid_diff;
    end
  end

  always_comb begin
    a_term = 40'(ddt) * 40'd36;
    b_term = 40'(nfid) * 40'd100;
    abs_diff = (a_term > b_term) ? (a_term - b_term) : (b_term - a_term);
  end

  // a mismatch over a long gap is forgiven while in sync
  assign sync_next = !(fail && ((nfid < 32'(max_gap)) || !in_sync));
  assign count_inc = (unsync_count != 16'hFFFF) ? (unsync_count + 16'd1) : unsync_count;

  // result of the request being committed
  always_comb begin
    res = '0;
    res.unsync_frames = unsync_count;
    case (item.req_type)
      tsc_pkg::REQ_TRIGGER: begin
        res.fiducial_delta = nfid;
        if (item.has_detector_data && !baseline_pending) begin
          if (!sync_next) begin
            res.out_of_sync = 1'b1;
            res.unsync_frames = count_inc;
            res.raise_alarm = (count_inc > unsync_limit) && alarm_armed;
          end else begin
            res.unsync_frames = '0;
          end
        end
      end
      tsc_pkg::REQ_RESYNC: begin
        res.unsync_frames = '0;
      end
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap <= tsc_pkg::MAX_GAP_RESET;
      unsync_limit <= tsc_pkg::UNSYNC_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tsc_pkg::CFG_MAX_GAP:      max_gap <= cfg_data;
        tsc_pkg::CFG_UNSYNC_LIMIT: unsync_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // arithmetic pipeline, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
      dsec <= $signed({1'b0, in_data.clock_seconds}) - $signed({1'b0, base_seconds});
      dnsec <= $signed({1'b0, in_data.clock_nanoseconds}) - $signed({1'b0, base_nanoseconds});
      ddt <= in_data.detector_time_ms - base_detector_time;
    end
    if (cmd.mul) begin
      quo <= 32'(recip_prod >> tsc_pkg::RECIP_SHIFT);
      // with |dnsec| below one second the difference is positive exactly here
      pos <= !dsec[32] && (dsec != '0);
    end
    if (cmd.roll) begin
      nroll <= pos ? (quo - {31'd0, borrow}) : '0;
    end
    if (cmd.nfid) begin
      nfid <= nfid_calc;
    end
    if (cmd.cmp) begin
      fail <= abs_diff > 40'(nfid);
    end
  end

  // state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_pending <= 1'b1;
      in_sync <= 1'b1;
      alarm_armed <= 1'b1;
      unsync_count <= '0;
      base_fiducial <= '0;
      base_seconds <= '0;
      base_nanoseconds <= '0;
      base_detector_time <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        out_data <= res;
        case (item.req_type)
          tsc_pkg::REQ_TRIGGER: begin
            if (item.has_detector_data) begin
              if (baseline_pending) begin
                baseline_pending <= 1'b0;
                base_fiducial <= item.fiducial;
                base_seconds <= item.clock_seconds;
                base_nanoseconds <= item.clock_nanoseconds;
                base_detector_time <= item.detector_time_ms;
              end else begin
                in_sync <= sync_next;
                if (!sync_next) begin
                  unsync_count <= count_inc;
                  if (res.raise_alarm) begin
                    alarm_armed <= 1'b0;
                  end
                end else begin
                  unsync_count <= '0;
                  base_fiducial <= item.fiducial;
                  base_seconds <= item.clock_seconds;
                  base_nanoseconds <= item.clock_nanoseconds;
                  base_detector_time <= item.detector_time_ms;
                end
              end
            end
          end
          tsc_pkg::REQ_RESET: begin
            baseline_pending <= 1'b1;
          end
          tsc_pkg::REQ_RESYNC: begin
            in_sync <= 1'b1;
            unsync_count <= '0;
            alarm_armed <= 1'b1;
          end
          tsc_pkg::REQ_NOP: ;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/trigger_timestamp_sync_checker.sv @@
// ----------------------------------------------------------------------------
// trigger_timestamp_sync_checker
// Checks detector timestamps against fiducials counted since a baseline.
//
//   channel   signals                        direction
//   in        in_valid, in_stall, in_data    request in
//   out       out_valid, out_stall, out_data result out
//   cfg       cfg_write, cfg_index, cfg_data register write
//
// A trigger steps through reciprocal multiply, rollover correction,
// fiducial delta, sync test and commit before the next request is
// accepted; its result is registered at commit. Reset, resync and
// no-op requests skip to commit. Reset is synchronous and restores
// the register defaults and the baseline. A stalled output holds its
// result; the block waits to commit the next one, so no result is lost.
// ----------------------------------------------------------------------------
module trigger_timestamp_sync_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tsc_pkg::out_item_t out_data,
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  tsc_pkg::cmd_t    cmd;
  tsc_pkg::status_t status;

  tsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tsc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
